@@ rtl/tlbp_pkg.sv @@
package tlbp_pkg;

    localparam int PAGE_W  = 7;
    localparam int FRAME_W = 6;
    localparam int CLK_W   = 24;
    localparam int FAULT_W = 16;
    localparam int CFG_W   = 6;

    localparam logic [CLK_W-1:0]   CLOCK_MAX = {CLK_W{1'b1}};
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    typedef enum logic [0:0] {
        REG_FRAMES = 1'b0,
        REG_TLB    = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_REF   = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        OUT_TLB_HIT   = 3'd0,
        OUT_TABLE_HIT = 3'd1,
        OUT_FAULT_NEW = 3'd2,
        OUT_FAULT_REP = 3'd3,
        OUT_RANGE     = 3'd4
    } outcome_t;

    // TLB operations issued by the sequencer, at most one per cycle
    typedef struct packed {
        logic preload;
        logic touch;
        logic insert;
        logic evict;
    } tlb_op_t;

endpackage

@@ rtl/tlbp_if.sv @@
interface tlbp_req_if
    import tlbp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [PAGE_W-1:0]   page;
    logic [PAGE_W-1:0]   page_count;

    modport source (output valid, command, page, page_count, input ready);
    modport sink   (input valid, command, page, page_count, output ready);
endinterface

interface tlbp_rsp_if
    import tlbp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [2:0]          outcome;
    logic [FRAME_W-1:0]  frame;
    logic [PAGE_W-1:0]   victim_page;
    logic [FAULT_W-1:0]  fault_count;

    modport source (output valid, outcome, frame, victim_page, fault_count, input ready);
    modport sink   (input valid, outcome, frame, victim_page, fault_count, output ready);
endinterface

@@ rtl/tlbp_page_mem.sv @@
module tlbp_page_mem
#(
    parameter int DEPTH = 65,
    parameter int AW    = 7,
    parameter int DW    = 31
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tlbp_tlb.sv @@
module tlbp_tlb
    import tlbp_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int SCW   = 4,
    parameter int FW    = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tlb_op_t            op,
    input  logic [SCW-1:0]     nt,
    input  logic [SCW-1:0]     preload_n,
    input  logic [PAGE_W-1:0]  page,
    input  logic [FW-1:0]      frame,
    input  logic [CLK_W-1:0]   now,
    input  logic [PAGE_W-1:0]  evict_page,
    output logic               hit,
    output logic [FW-1:0]      hit_frame
);

    localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]  valid_reg;
    logic [PAGE_W-1:0] page_reg [SLOTS];
    logic [FW-1:0]     frame_reg [SLOTS];
    logic [CLK_W-1:0]  last_reg [SLOTS];

    logic [SIW-1:0] hit_slot;
    logic [SIW-1:0] pick;
    logic           found;

    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        hit_frame = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!hit && (32'(s) < 32'(nt)) && valid_reg[s] && (page_reg[s] == page))
            begin
                hit       = 1'b1;
                hit_slot  = SIW'(s);
                hit_frame = frame_reg[s];
            end
        end
    end

    // lowest empty slot, else LRU slot with ties to the lowest
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!found && (32'(s) < 32'(nt)) && !valid_reg[s])
            begin
                found = 1'b1;
                pick  = SIW'(s);
            end
        end
        if (!found)
        begin
            for (int s = 1; s < SLOTS; s++)
            begin
                if ((32'(s) < 32'(nt)) && (last_reg[s] < last_reg[pick]))
                begin
                    pick = SIW'(s);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (op.preload)
                begin
                    valid_reg[s] <= (32'(s) < 32'(preload_n));
                end
                else if (op.evict && valid_reg[s] && (page_reg[s] == evict_page))
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (op.insert && (SIW'(s) == pick))
                begin
                    valid_reg[s] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            if (op.preload)
            begin
                if (32'(s) < 32'(preload_n))
                begin
                    page_reg[s]  <= PAGE_W'(s + 1);
                    frame_reg[s] <= FW'(s + 1);
                end
                else
                begin
                    page_reg[s]  <= '0;
                    frame_reg[s] <= '0;
                end
                last_reg[s] <= '0;
            end
            else if (op.evict && valid_reg[s] && (page_reg[s] == evict_page))
            begin
                page_reg[s]  <= '0;
                frame_reg[s] <= '0;
                last_reg[s]  <= '0;
            end
            else if (op.insert && (SIW'(s) == pick))
            begin
                page_reg[s]  <= page;
                frame_reg[s] <= frame;
                last_reg[s]  <= now;
            end
            else if (op.touch && hit && (SIW'(s) == hit_slot))
            begin
                last_reg[s] <= now;
            end
        end
    end

endmodule

@@ rtl/tlb_page_table_lru_pager.sv @@
// Demand-paging translator with a small TLB and LRU page replacement.
// Input channel req carries command, page and page_count; output channel rsp
// carries outcome, frame, victim_page and fault_count, one transfer per page
// reference and none for a start command. Configuration (frames_in_use,
// tlb_entries) is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block does not enforce. One item is
// worked on at a time; req.ready is high when the sequencer is idle, also
// while a result still waits in the output register. An out-of-range
// reference goes straight to the output; a TLB miss reads the page table;
// a fault with no free frame then scans the page-table memory sequentially
// for the LRU page (one entry per cycle, one read port). A start command
// sweeps the page table clear, then writes each preloaded page's entry.
// Reset sets frames_in_use to 32, tlb_entries to 8 and the page count to 0,
// so every reference is out of range until the first start.
// When rsp stalls, the result holds in the output register; a finished
// item waits in the sequencer until the register is free.
module tlb_page_table_lru_pager
    import tlbp_pkg::*;
#(
    parameter int MAX_PAGES  = 64,
    parameter int MAX_FRAMES = 32,
    parameter int TLB_SLOTS  = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    tlbp_req_if.sink          req,
    tlbp_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int AW  = $clog2(MAX_PAGES + 1);
    localparam int FW  = $clog2(MAX_FRAMES + 2);
    localparam int SCW = $clog2(TLB_SLOTS + 1);
    localparam int DW  = 1 + FW + CLK_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CLEAR   = 9'b000000010,
        S_PRELOAD = 9'b000000100,
        S_LOOKUP  = 9'b000001000,
        S_READ    = 9'b000010000,
        S_SCAN    = 9'b000100000,
        S_EVICT   = 9'b001000000,
        S_FINISH  = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]         frames_cfg_reg;
    logic [3:0]         tlb_cfg_reg;
    logic [CLK_W-1:0]   use_clock_reg;
    logic [FW-1:0]      next_free_reg;
    logic [FAULT_W-1:0] faults_reg;
    logic [PAGE_W-1:0]  process_pages_reg;
    logic               out_valid_reg;

    logic [PAGE_W-1:0]  page_reg;
    logic [PAGE_W-1:0]  count_reg;
    logic [SCW-1:0]     n_reg;
    logic [AW-1:0]      addr_reg;
    logic [CLK_W-1:0]   now_reg;
    logic [AW-1:0]      best_reg;
    logic [CLK_W-1:0]   best_last_reg;
    logic [FW-1:0]      best_frame_reg;
    logic [2:0]         res_outcome_reg;
    logic [FW-1:0]      res_frame_reg;
    logic [PAGE_W-1:0]  res_victim_reg;
    logic [2:0]         out_outcome_reg;
    logic [FW-1:0]      out_frame_reg;
    logic [PAGE_W-1:0]  out_victim_reg;
    logic [FAULT_W-1:0] out_faults_reg;

    logic [FW-1:0]      eff_frames;
    logic [31:0]        t32;
    logic [SCW-1:0]     nt;
    logic [SCW-1:0]     n_calc;
    logic [PAGE_W-1:0]  cnt_sat;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DW-1:0]      mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [DW-1:0]      mem_rdata;
    logic               rd_valid;
    logic [FW-1:0]      rd_frame;
    logic [CLK_W-1:0]   rd_last;

    tlb_op_t            tlb_op;
    logic               tlb_hit;
    logic [FW-1:0]      tlb_hit_frame;
    logic [FW-1:0]      ins_frame;

    logic               accept;
    logic               out_load;
    logic               scan_better;
    logic               page_ok;

    assign {rd_valid, rd_frame, rd_last} = mem_rdata;

    always_comb
    begin
        if (frames_cfg_reg < 6'd2)
        begin
            eff_frames = FW'(2);
        end
        else if (32'(frames_cfg_reg) > MAX_FRAMES)
        begin
            eff_frames = FW'(MAX_FRAMES);
        end
        else
        begin
            eff_frames = FW'(frames_cfg_reg);
        end
    end

    always_comb
    begin
        t32 = 32'(tlb_cfg_reg);
        if (t32 < 32'd1)
        begin
            t32 = 32'd1;
        end
        else if (t32 > TLB_SLOTS)
        begin
            t32 = 32'(TLB_SLOTS);
        end
        if (t32 > 32'(eff_frames) - 32'd1)
        begin
            t32 = 32'(eff_frames) - 32'd1;
        end
        nt = SCW'(t32);
    end

    always_comb
    begin
        if (32'(req.page_count) > MAX_PAGES)
        begin
            cnt_sat = PAGE_W'(MAX_PAGES);
        end
        else
        begin
            cnt_sat = req.page_count;
        end
        if (32'(nt) < 32'(count_reg))
        begin
            n_calc = nt;
        end
        else
        begin
            n_calc = SCW'(count_reg);
        end
    end

    assign accept   = req.valid && (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);
    assign page_ok  = (req.page != '0) && (req.page <= process_pages_reg);
    assign scan_better = rd_valid && ((best_reg == '0) || (rd_last < best_last_reg));
    assign ins_frame = (state_reg == S_READ) ? (rd_valid ? rd_frame : next_free_reg)
                                             : ((best_reg == '0) ? FW'(1) : best_frame_reg);

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = '0;
        mem_raddr  = AW'(page_reg);
        tlb_op     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_START)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (page_ok)
                    begin
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == AW'(MAX_PAGES))
                begin
                    tlb_op.preload = 1'b1;
                    state_next = (n_calc == '0) ? S_IDLE : S_PRELOAD;
                end
            end
            S_PRELOAD:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, FW'(addr_reg), {CLK_W{1'b0}}};
                if (addr_reg == AW'(n_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOOKUP:
            begin
                if (tlb_hit)
                begin
                    tlb_op.touch = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(page_reg);
                    mem_wdata  = {1'b1, tlb_hit_frame, now_reg};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (rd_valid || (next_free_reg <= eff_frames))
                begin
                    tlb_op.insert = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(page_reg);
                    mem_wdata  = {1'b1, ins_frame, now_reg};
                    state_next = S_OUT;
                end
                else
                begin
                    mem_raddr  = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                mem_raddr = addr_reg + AW'(1);
                if (addr_reg == AW'(MAX_PAGES))
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                if (best_reg != '0)
                begin
                    tlb_op.evict = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = best_reg;
                    mem_wdata = '0;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                tlb_op.insert = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = AW'(page_reg);
                mem_wdata  = {1'b1, ins_frame, now_reg};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            frames_cfg_reg    <= 6'd32;
            tlb_cfg_reg       <= 4'd8;
            use_clock_reg     <= CLK_W'(1);
            next_free_reg     <= FW'(1);
            faults_reg        <= '0;
            process_pages_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_FRAMES: frames_cfg_reg <= cfg_data;
                    REG_TLB:    tlb_cfg_reg    <= cfg_data[3:0];
                    default:    tlb_cfg_reg    <= tlb_cfg_reg;
                endcase
            end
            if (accept && (req.command == CMD_REF) && page_ok
                && (use_clock_reg != CLOCK_MAX))
            begin
                use_clock_reg <= use_clock_reg + CLK_W'(1);
            end
            if ((state_reg == S_CLEAR) && (addr_reg == AW'(MAX_PAGES)))
            begin
                process_pages_reg <= count_reg;
                faults_reg        <= '0;
                use_clock_reg     <= CLK_W'(1);
                next_free_reg     <= FW'(n_calc) + FW'(1);
            end
            if ((state_reg == S_READ) && !rd_valid)
            begin
                if (faults_reg != FAULT_MAX)
                begin
                    faults_reg <= faults_reg + FAULT_W'(1);
                end
                if (next_free_reg <= eff_frames)
                begin
                    next_free_reg <= next_free_reg + FW'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                page_reg        <= req.page;
                count_reg       <= cnt_sat;
                addr_reg        <= '0;
                now_reg         <= use_clock_reg;
                res_outcome_reg <= OUT_RANGE;
                res_frame_reg   <= '0;
                res_victim_reg  <= '0;
            end
            S_CLEAR:
            begin
                addr_reg <= (addr_reg == AW'(MAX_PAGES)) ? AW'(1) : addr_reg + AW'(1);
                n_reg    <= n_calc;
            end
            S_PRELOAD:
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            S_LOOKUP:
            begin
                res_outcome_reg <= OUT_TLB_HIT;
                res_frame_reg   <= tlb_hit_frame;
            end
            S_READ:
            begin
                res_outcome_reg <= rd_valid ? OUT_TABLE_HIT : OUT_FAULT_NEW;
                res_frame_reg   <= ins_frame;
                addr_reg        <= AW'(1);
                best_reg        <= '0;
                best_last_reg   <= '0;
                best_frame_reg  <= '0;
            end
            S_SCAN:
            begin
                if (scan_better)
                begin
                    best_reg       <= addr_reg;
                    best_last_reg  <= rd_last;
                    best_frame_reg <= rd_frame;
                end
                addr_reg <= addr_reg + AW'(1);
            end
            S_EVICT:
            begin
                res_outcome_reg <= OUT_FAULT_REP;
                res_frame_reg   <= ins_frame;
                res_victim_reg  <= PAGE_W'(best_reg);
            end
            default:
            begin
                res_outcome_reg <= res_outcome_reg;
            end
        endcase
        if (out_load)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_frame_reg   <= res_frame_reg;
            out_victim_reg  <= res_victim_reg;
            out_faults_reg  <= faults_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.outcome     = out_outcome_reg;
    assign rsp.frame       = FRAME_W'(out_frame_reg);
    assign rsp.victim_page = out_victim_reg;
    assign rsp.fault_count = out_faults_reg;

    tlbp_page_mem #(
        .DEPTH (MAX_PAGES + 1),
        .AW    (AW),
        .DW    (DW)
    ) u_page_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tlbp_tlb #(
        .SLOTS (TLB_SLOTS),
        .SCW   (SCW),
        .FW    (FW)
    ) u_tlb (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (tlb_op),
        .nt         (nt),
        .preload_n  (n_calc),
        .page       (page_reg),
        .frame      (ins_frame),
        .now        (now_reg),
        .evict_page (PAGE_W'(best_reg)),
        .hit        (tlb_hit),
        .hit_frame  (tlb_hit_frame)
    );

endmodule

@@ bench/tb_tlb_page_table_lru_pager.sv @@
module tb_tlb_page_table_lru_pager;
    import tlbp_pkg::*;

    localparam int NPAGES = 64;
    localparam int NFRAMES = 32;
    localparam int NSLOTS = 8;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic              command;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] page_count;
    } req_item_t;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  victim_page;
        logic [FAULT_W-1:0] fault_count;
    } translation_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    tlbp_req_if req_ch();
    tlbp_rsp_if rsp_ch();

    tlb_page_table_lru_pager dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the pager
    logic [5:0]  frames_reg;
    logic [3:0]  tlb_reg;
    logic [FRAME_W-1:0] pt_frame [1:NPAGES];
    logic        pt_valid [1:NPAGES];
    logic [CLK_W-1:0] pt_used [1:NPAGES];
    logic [PAGE_W-1:0] tl_page [NSLOTS];
    logic        tl_valid [NSLOTS];
    logic [FRAME_W-1:0] tl_frame [NSLOTS];
    logic [CLK_W-1:0] tl_used [NSLOTS];
    logic [CLK_W-1:0] use_tick;
    int          next_frame;
    logic [FAULT_W-1:0] faults;
    int          proc_pages;

    req_item_t    pending_reqs[$];
    translation_t expected_xlats[$];
    int  errors = 0;
    int  cycles = 0;
    int  results_seen = 0;
    int  refs_sent = 0;
    int  starts_sent = 0;
    bit  quiet = 0;
    bit  hold_src = 0;
    int  src_gap = 0;
    int  snk_gap = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int frames_eff();
        int f;
        f = frames_reg;
        if (f < 2) f = 2;
        if (f > NFRAMES) f = NFRAMES;
        return f;
    endfunction

    function automatic int slots_eff();
        int t;
        t = tlb_reg;
        if (t < 1) t = 1;
        if (t > NSLOTS) t = NSLOTS;
        if (t > frames_eff() - 1) t = frames_eff() - 1;
        return t;
    endfunction

    task automatic clear_shadow();
        for (int q = 1; q <= NPAGES; q++)
        begin
            pt_frame[q] = '0;
            pt_valid[q] = 1'b0;
            pt_used[q] = '0;
        end
        for (int s = 0; s < NSLOTS; s++)
        begin
            tl_page[s] = '0;
            tl_valid[s] = 1'b0;
            tl_frame[s] = '0;
            tl_used[s] = '0;
        end
    endtask

    task automatic shadow_reset();
        frames_reg = 6'd32;
        tlb_reg = 4'd8;
        clear_shadow();
        use_tick = CLK_W'(1);
        next_frame = 1;
        faults = '0;
        proc_pages = 0;
    endtask

    task automatic queue_req(req_item_t it);
        pending_reqs = {pending_reqs, it};
    endtask

    task automatic tlb_fill(int p, int fr, logic [CLK_W-1:0] now, int nt);
        int pick;
        bit found;
        pick = 0;
        found = 0;
        for (int s = 0; s < nt && !found; s++)
            if (!tl_valid[s])
            begin
                pick = s;
                found = 1;
            end
        if (!found)
            for (int s = 1; s < nt; s++)
                if (tl_used[s] < tl_used[pick]) pick = s;
        tl_valid[pick] = 1'b1;
        tl_page[pick] = PAGE_W'(p);
        tl_frame[pick] = FRAME_W'(fr);
        tl_used[pick] = now;
    endtask

    // advance the shadow by one transfer; queues the expected translation for a page reference
    task automatic translate(req_item_t it);
        int nt, p, fr, victim, best, cnt, n;
        bit hit;
        logic [CLK_W-1:0] now;
        translation_t r;
        outcome_t oc;
        nt = slots_eff();
        p = it.page;
        fr = 0;
        victim = 0;
        hit = 0;
        if (it.command == CMD_START)
        begin
            cnt = it.page_count;
            if (cnt > NPAGES) cnt = NPAGES;
            clear_shadow();
            proc_pages = cnt;
            n = nt < cnt ? nt : cnt;
            for (int k = 1; k <= n; k++)
            begin
                pt_frame[k] = FRAME_W'(k);
                pt_valid[k] = 1'b1;
                tl_valid[k-1] = 1'b1;
                tl_page[k-1] = PAGE_W'(k);
                tl_frame[k-1] = FRAME_W'(k);
            end
            next_frame = n + 1;
            faults = '0;
            use_tick = CLK_W'(1);
            return;
        end
        if (p < 1 || p > proc_pages)
        begin
            r.outcome = OUT_RANGE;
            r.frame = '0;
            r.victim_page = '0;
            r.fault_count = faults;
            expected_xlats = {expected_xlats, r};
            return;
        end
        now = use_tick;
        if (use_tick != CLOCK_MAX) use_tick++;
        for (int s = 0; s < nt && !hit; s++)
            if (tl_valid[s] && tl_page[s] == p)
            begin
                hit = 1;
                fr = tl_frame[s];
                tl_used[s] = now;
            end
        if (hit)
            oc = OUT_TLB_HIT;
        else if (pt_valid[p])
        begin
            oc = OUT_TABLE_HIT;
            fr = pt_frame[p];
            tlb_fill(p, fr, now, nt);
        end
        else
        begin
            if (faults != FAULT_MAX) faults++;
            if (next_frame <= frames_eff())
            begin
                oc = OUT_FAULT_NEW;
                fr = next_frame;
                next_frame++;
            end
            else
            begin
                oc = OUT_FAULT_REP;
                best = 0;
                for (int q = 1; q <= NPAGES; q++)
                    if (pt_valid[q] && (best == 0 || pt_used[q] < pt_used[best]))
                        best = q;
                if (best == 0)
                    fr = 1;
                else
                begin
                    victim = best;
                    fr = pt_frame[best];
                    pt_valid[best] = 1'b0;
                    pt_frame[best] = '0;
                    for (int s = 0; s < NSLOTS; s++)
                        if (tl_valid[s] && tl_page[s] == best)
                        begin
                            tl_valid[s] = 1'b0;
                            tl_page[s] = '0;
                            tl_frame[s] = '0;
                            tl_used[s] = '0;
                        end
                end
            end
            pt_frame[p] = FRAME_W'(fr);
            pt_valid[p] = 1'b1;
            tlb_fill(p, fr, now, nt);
        end
        pt_used[p] = now;
        r.outcome = oc;
        r.frame = FRAME_W'(fr);
        r.victim_page = PAGE_W'(victim);
        r.fault_count = faults;
        expected_xlats = {expected_xlats, r};
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    function automatic req_item_t mk_start(int cnt);
        req_item_t it;
        it.command = CMD_START;
        it.page = 7'($urandom);
        it.page_count = PAGE_W'(cnt);
        return it;
    endfunction

    function automatic req_item_t mk_ref(int p);
        req_item_t it;
        it.command = CMD_REF;
        it.page = PAGE_W'(p);
        it.page_count = 7'($urandom);
        return it;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.command <= 1'b0;
            req_ch.page <= '0;
            req_ch.page_count <= '0;
            src_gap <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_ch.valid)
                begin
                    translate({req_ch.command, req_ch.page, req_ch.page_count});
                    pending_reqs.delete(0);
                end
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    src_gap <= $urandom_range(1, 13);
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !hold_src)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.command <= pending_reqs[0].command;
                    req_ch.page <= pending_reqs[0].page;
                    req_ch.page_count <= pending_reqs[0].page_count;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        translation_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            snk_gap <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_xlats.size() == 0)
                begin
                    report("unexpected result, outcome", rsp_ch.outcome, -1);
                end
                else
                begin
                    want = expected_xlats[0];
                    expected_xlats.delete(0);
                    if (rsp_ch.outcome !== want.outcome)
                        report("outcome", rsp_ch.outcome, want.outcome);
                    if (rsp_ch.frame !== want.frame)
                        report("frame", rsp_ch.frame, want.frame);
                    if (rsp_ch.victim_page !== want.victim_page)
                        report("victim_page", rsp_ch.victim_page, want.victim_page);
                    if (rsp_ch.fault_count !== want.fault_count)
                        report("fault_count", rsp_ch.fault_count, want.fault_count);
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                snk_gap <= $urandom_range(1, 13);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_tlb_page_table_lru_pager: done, errors");
            $finish;
        end

    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_xlats.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAMES) frames_reg = 6'(val);
        else tlb_reg = 4'(val);
    endtask

    // one process: mostly in-range references with locality, some noise
    task automatic queue_process(int cnt, int nrefs);
        int hot;
        queue_req(mk_start(cnt));
        starts_sent++;
        for (int i = 0; i < nrefs; i++)
        begin
            hot = $urandom_range(0, 99);
            if (hot < 5)
                queue_req(mk_ref($urandom_range(0, 127)));
            else if (hot < 55 && cnt > 1)
                queue_req(mk_ref($urandom_range(1, cnt < 6 ? cnt : 6)));
            else
                queue_req(mk_ref($urandom_range(1, cnt > 0 ? cnt : 1)));
            refs_sent++;
        end
    endtask

    initial
    begin
        int fset [6] = '{2, 3, 8, 16, 32, 63};
        int tset [6] = '{1, 0, 8, 15, 4, 7};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAMES;
        cfg_data = '0;
        shadow_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: references before any start, bounds, page_count 0 and 127
        queue_req(mk_ref(1));
        queue_req(mk_ref(127));
        queue_req(mk_start(0));
        queue_req(mk_ref(1));
        queue_req(mk_start(127));
        queue_req(mk_ref(64));
        queue_req(mk_ref(65));
        queue_req(mk_ref(0));
        queue_req(mk_ref(1));
        queue_req(mk_ref(20));
        queue_req(mk_ref(20));
        queue_req(mk_ref(9));
        queue_req(mk_ref(9));
        refs_sent += 11;
        starts_sent += 2;
        drain();

        // small frame pool forces replacement; sender held while the process is queued, released before the drain
        write_reg(REG_FRAMES, 2);
        write_reg(REG_TLB, 1);
        hold_src = 1;
        queue_process(5, 12);
        repeat (30) @(posedge clk);
        hold_src = 0;
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_FRAMES, ph < 6 ? fset[ph] : $urandom_range(0, 63));
            write_reg(REG_TLB, ph < 6 ? tset[ph] : $urandom_range(0, 15));
            if (ph == 11) quiet = 1;
            for (int k = 0; k < 3; k++)
                queue_process($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                        : $urandom_range(1, 40), 50);
            drain();
        end

        $display("covered %0d starts and %0d page references, %0d results checked",
                 starts_sent, refs_sent, results_seen);
        $display("frame pools 2..63 and TLB sizes 0..15 exercised with LRU eviction");
        if (errors == 0)
            $display("tb_tlb_page_table_lru_pager: done, clean");
        else
            $display("tb_tlb_page_table_lru_pager: done, errors");
        $finish;
    end
endmodule

@@ tlb_page_table_lru_pager.f @@
rtl/tlbp_pkg.sv
rtl/tlbp_if.sv
rtl/tlbp_page_mem.sv
rtl/tlbp_tlb.sv
rtl/tlb_page_table_lru_pager.sv
bench/tb_tlb_page_table_lru_pager.sv
